// ----- src/gfsg_pkg.sv -----
// Package for the free-streaming gather block: field widths, item types,
// fixed-point constants and the quarter-wave sine polynomial.
// Used by every module under src except gfsg_ram; depends on nothing.
`default_nettype none

package gfsg_pkg;

  // Field widths of the stream items
  localparam int unsigned CELL_W      = 12;
  localparam int unsigned THETA_IDX_W = 4;
  localparam int unsigned PHI_IDX_W   = 5;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned RATIO_W     = 16;
  localparam int unsigned ADDR_W      = 12;
  localparam int unsigned STORE_DEPTH = 4096;

  // Grid axes never exceed 64 cells, so a coordinate fits in six bits
  localparam int unsigned COORD_W = 6;

  // Q1.15 trig values span -1.0 .. +1.0 inclusive
  localparam int unsigned TRIG_W = 17;
  // Product of two trig values, or a cosine scaled by 2^15
  localparam int unsigned PROD_W = 33;
  // Upstream coordinate in Q38 cells; wide enough for 63 cells plus the largest step
  localparam int unsigned FRAC_W = 38;
  localparam int unsigned V_W    = 48;
  localparam int unsigned R_W    = V_W - FRAC_W;

  // Load scaling: round(2^32 / (4*pi)), signed product width
  localparam logic [28:0] NORM_Q32 = 29'd341782638;
  localparam int unsigned LOAD_W   = 62;

  // Short queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // Taylor coefficients of sin(x*pi/2) in Q30
  localparam longint unsigned TC1 = 64'd1686629713;
  localparam longint unsigned TC3 = 64'd693598672;
  localparam longint unsigned TC5 = 64'd85569306;
  localparam longint unsigned TC7 = 64'd5026995;
  localparam longint unsigned TC9 = 64'd172273;

  localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd256;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CFG_STEP_X = 2'd0,
    CFG_STEP_Y = 2'd1,
    CFG_STEP_Z = 2'd2
  } cfg_idx_e;

  // Step ratios per axis, unsigned Q8.8 cells
  typedef struct packed {
    logic [RATIO_W-1:0] x;
    logic [RATIO_W-1:0] y;
    logic [RATIO_W-1:0] z;
  } ratio_t;

  // Classified item handed from front to back
  typedef struct packed {
    op_e                 op;
    logic                outside;
    logic [CELL_W-1:0]   cell_idx;
    logic [COORD_W-1:0]  cx;
    logic [COORD_W-1:0]  cy;
    logic [COORD_W-1:0]  cz;
    logic [PROD_W-1:0]   prod_x;
    logic [PROD_W-1:0]   prod_y;
    logic [PROD_W-1:0]   prod_z;
    logic [VALUE_W-1:0]  sample;
  } item_t;

  // Quarter-wave sine magnitude in Q15 for x in Q30, clamped to 1.0
  function automatic int quarter_poly(input longint unsigned x);
    longint unsigned x2;
    longint unsigned acc;
    longint unsigned v;
    x2  = (x * x) >> 30;
    acc = TC7 - ((x2 * TC9) >> 30);
    acc = TC5 - ((x2 * acc) >> 30);
    acc = TC3 - ((x2 * acc) >> 30);
    acc = TC1 - ((x2 * acc) >> 30);
    v   = (x * acc) >> 30;
    v   = (v + 64'd16384) >> 15;
    if (v > 64'd32768) begin
      v = 64'd32768;
    end
    return int'(v);
  endfunction

endpackage

`default_nettype wire

// ----- src/gfsg_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Holds the density store; no dependencies.
`default_nettype none

module gfsg_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- src/gfsg_queue.sv -----
// Short FIFO of classified items between the front and the back part.
// Depends on gfsg_pkg for the item type and depth.
`default_nettype none

module gfsg_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire gfsg_pkg::item_t item_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output gfsg_pkg::item_t    item_o,
  output logic               empty_o
);

  gfsg_pkg::item_t                 slot_q [gfsg_pkg::QUEUE_DEPTH];
  logic [gfsg_pkg::QPTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [gfsg_pkg::QPTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [gfsg_pkg::QPTR_W:0]       count_q, count_d;

  assign full_o  = (count_q == (gfsg_pkg::QPTR_W + 1)'(gfsg_pkg::QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign item_o  = slot_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

// ----- src/gfsg_front.sv -----
// Front part: accepts input words, splits the flat cell index into
// coordinates, looks up direction trig values and forms their products.
// Depends on gfsg_pkg; feeds gfsg_queue.
`default_nettype none

module gfsg_front #(
  parameter int unsigned X_SIZE      = 16,
  parameter int unsigned Y_SIZE      = 16,
  parameter int unsigned Z_SIZE      = 16,
  parameter int unsigned THETA_STEPS = 16,
  parameter int unsigned PHI_STEPS   = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_valid_i,
  output logic                                     s_ready_o,
  input  wire gfsg_pkg::op_e                       s_op_i,
  input  wire logic [gfsg_pkg::CELL_W-1:0]         s_cell_i,
  input  wire logic [gfsg_pkg::THETA_IDX_W-1:0]    s_theta_i,
  input  wire logic [gfsg_pkg::PHI_IDX_W-1:0]      s_phi_i,
  input  wire logic [gfsg_pkg::VALUE_W-1:0]        s_sample_i,
  output logic                                     push_o,
  output gfsg_pkg::item_t                          item_o,
  input  wire logic                                full_i
);

  localparam int unsigned THETA_N = 2 ** gfsg_pkg::THETA_IDX_W;
  localparam int unsigned PHI_N   = 2 ** gfsg_pkg::PHI_IDX_W;
  localparam longint unsigned THETA_DEN = 2 * THETA_STEPS;
  localparam longint unsigned PHI_DEN   = PHI_STEPS;

  // Division by a constant through a rounded-up reciprocal; exact for 12-bit cells
  localparam int unsigned     PLANE = Y_SIZE * Z_SIZE;
  localparam int unsigned     CELLS = X_SIZE * PLANE;
  localparam int unsigned     REC_S = 25;
  localparam int unsigned     REC_W = gfsg_pkg::CELL_W + REC_S;
  localparam longint unsigned M_PLANE = ((64'd1 << REC_S) + PLANE - 1) / PLANE;
  localparam longint unsigned M_Z     = ((64'd1 << REC_S) + Z_SIZE - 1) / Z_SIZE;

  localparam int unsigned TW = gfsg_pkg::TRIG_W;
  localparam int unsigned CW = gfsg_pkg::CELL_W;

  // Trig tables, one entry per possible angle index
  logic signed [TW-1:0] sin_theta [THETA_N];
  logic signed [TW-1:0] cos_theta [THETA_N];
  logic signed [TW-1:0] sin_phi   [PHI_N];
  logic signed [TW-1:0] cos_phi   [PHI_N];

  for (genvar i = 0; i < THETA_N; i++) begin : g_theta
    localparam longint unsigned A  = 4 * i;
    localparam longint unsigned R  = A % THETA_DEN;
    localparam longint unsigned QD = (A / THETA_DEN) % 4;
    localparam longint unsigned RS = (QD % 2 == 1) ? THETA_DEN - R : R;
    localparam longint unsigned RC = (QD % 2 == 0) ? THETA_DEN - R : R;
    localparam int MS = (RS >= THETA_DEN) ? 32768 :
                        gfsg_pkg::quarter_poly((RS << 30) / THETA_DEN);
    localparam int MC = (RC >= THETA_DEN) ? 32768 :
                        gfsg_pkg::quarter_poly((RC << 30) / THETA_DEN);
    localparam bit NS = (QD >= 2);
    localparam bit NC = (QD == 1) || (QD == 2);
    assign sin_theta[i] = TW'(NS ? -MS : MS);
    assign cos_theta[i] = TW'(NC ? -MC : MC);
  end

  for (genvar i = 0; i < PHI_N; i++) begin : g_phi
    localparam longint unsigned A  = 4 * i;
    localparam longint unsigned R  = A % PHI_DEN;
    localparam longint unsigned QD = (A / PHI_DEN) % 4;
    localparam longint unsigned RS = (QD % 2 == 1) ? PHI_DEN - R : R;
    localparam longint unsigned RC = (QD % 2 == 0) ? PHI_DEN - R : R;
    localparam int MS = (RS >= PHI_DEN) ? 32768 :
                        gfsg_pkg::quarter_poly((RS << 30) / PHI_DEN);
    localparam int MC = (RC >= PHI_DEN) ? 32768 :
                        gfsg_pkg::quarter_poly((RC << 30) / PHI_DEN);
    localparam bit NS = (QD >= 2);
    localparam bit NC = (QD == 1) || (QD == 2);
    assign sin_phi[i] = TW'(NS ? -MS : MS);
    assign cos_phi[i] = TW'(NC ? -MC : MC);
  end

  logic front_adv;

  // Stage 1: accepted word
  logic                                  f1_vld_q;
  gfsg_pkg::op_e                         f1_op_q;
  logic [CW-1:0]                         f1_cell_q;
  logic [gfsg_pkg::THETA_IDX_W-1:0]      f1_theta_q;
  logic [gfsg_pkg::PHI_IDX_W-1:0]        f1_phi_q;
  logic [gfsg_pkg::VALUE_W-1:0]          f1_sample_q;

  // Stage 2: quotients and trig values
  logic                                  f2_vld_q;
  gfsg_pkg::op_e                         f2_op_q;
  logic [CW-1:0]                         f2_cell_q;
  logic                                  f2_out_q, f2_out_d;
  logic [CW-1:0]                         f2_qx_q, f2_qx_d;
  logic [CW-1:0]                         f2_qz_q, f2_qz_d;
  logic signed [TW-1:0]                  f2_st_q, f2_ct_q, f2_sp_q, f2_cp_q;
  logic [gfsg_pkg::VALUE_W-1:0]          f2_sample_q;
  logic [REC_W-1:0]                      prod_plane, prod_z;

  // Stage 3: finished item
  logic                                  f3_vld_q;
  gfsg_pkg::item_t                       f3_item_q, f3_item_d;
  logic signed [2*TW-1:0]                pxy, pyy;
  logic [CW-1:0]                         iy, iz;

  // Stall the whole front only when the last stage cannot push
  assign front_adv = !f3_vld_q || !full_i;
  assign s_ready_o = front_adv;
  assign push_o    = f3_vld_q && !full_i;
  assign item_o    = f3_item_q;

  // Quotients by the plane size and by the z size
  always_comb begin
    prod_plane = REC_W'(f1_cell_q) * REC_W'(M_PLANE);
    prod_z     = REC_W'(f1_cell_q) * REC_W'(M_Z);
    f2_qx_d    = prod_plane[REC_S +: CW];
    f2_qz_d    = prod_z[REC_S +: CW];
    f2_out_d   = (32'(f1_cell_q) >= 32'(CELLS));
  end

  // Remainders and direction products
  always_comb begin
    iz  = CW'(f2_cell_q - CW'(f2_qz_q * CW'(Z_SIZE)));
    iy  = CW'(f2_qz_q - CW'(f2_qx_q * CW'(Y_SIZE)));
    pxy = f2_st_q * f2_cp_q;
    pyy = f2_st_q * f2_sp_q;
    f3_item_d.op       = f2_op_q;
    f3_item_d.outside  = f2_out_q;
    f3_item_d.cell_idx = f2_cell_q;
    f3_item_d.cx       = f2_qx_q[gfsg_pkg::COORD_W-1:0];
    f3_item_d.cy       = iy[gfsg_pkg::COORD_W-1:0];
    f3_item_d.cz       = iz[gfsg_pkg::COORD_W-1:0];
    f3_item_d.prod_x   = pxy[gfsg_pkg::PROD_W-1:0];
    f3_item_d.prod_y   = pyy[gfsg_pkg::PROD_W-1:0];
    f3_item_d.prod_z   = {f2_ct_q[TW-1], f2_ct_q, 15'b0};
    f3_item_d.sample   = f2_sample_q;
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
      f2_vld_q <= 1'b0;
      f3_vld_q <= 1'b0;
    end else if (front_adv) begin
      f1_vld_q <= s_valid_i;
      f2_vld_q <= f1_vld_q;
      f3_vld_q <= f2_vld_q;
    end
  end

  // Payload, moved on together with the valid bits
  always_ff @(posedge clk_i) begin
    if (front_adv) begin
      f1_op_q     <= s_op_i;
      f1_cell_q   <= s_cell_i;
      f1_theta_q  <= s_theta_i;
      f1_phi_q    <= s_phi_i;
      f1_sample_q <= s_sample_i;

      f2_op_q     <= f1_op_q;
      f2_cell_q   <= f1_cell_q;
      f2_out_q    <= f2_out_d;
      f2_qx_q     <= f2_qx_d;
      f2_qz_q     <= f2_qz_d;
      f2_st_q     <= sin_theta[f1_theta_q];
      f2_ct_q     <= cos_theta[f1_theta_q];
      f2_sp_q     <= sin_phi[f1_phi_q];
      f2_cp_q     <= cos_phi[f1_phi_q];
      f2_sample_q <= f1_sample_q;

      f3_item_q   <= f3_item_d;
    end
  end

endmodule

`default_nettype wire

// ----- src/gfsg_back.sv -----
// Back part: scales loads and writes them to the density store, moves
// queries upstream, rounds, bounds-checks and reads the store.
// Depends on gfsg_pkg and gfsg_ram; fed by gfsg_queue.
`default_nettype none

module gfsg_back #(
  parameter int unsigned X_SIZE = 16,
  parameter int unsigned Y_SIZE = 16,
  parameter int unsigned Z_SIZE = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire gfsg_pkg::ratio_t              ratio_i,
  input  wire gfsg_pkg::item_t               item_i,
  input  wire logic                          empty_i,
  output logic                               pop_o,
  output logic                               m_valid_o,
  input  wire logic                          m_ready_i,
  output logic [gfsg_pkg::VALUE_W-1:0]       m_value_o,
  output logic                               m_in_bounds_o
);

  localparam int unsigned V_W    = gfsg_pkg::V_W;
  localparam int unsigned R_W    = gfsg_pkg::R_W;
  localparam int unsigned CRD_W  = gfsg_pkg::COORD_W;
  localparam int unsigned LOAD_W = gfsg_pkg::LOAD_W;
  localparam int unsigned DP_W   = gfsg_pkg::RATIO_W + gfsg_pkg::PROD_W + 1;
  localparam int unsigned PLANE  = Y_SIZE * Z_SIZE;
  localparam int unsigned FULL_W = $clog2(X_SIZE * PLANE);

  // Round Q38 half away from zero to whole cells
  function automatic logic [R_W-1:0] round_cell(input logic [V_W-1:0] v);
    logic [V_W-1:0] sum;
    sum = v + V_W'(64'd1 << (gfsg_pkg::FRAC_W - 1)) - V_W'(v[V_W-1]);
    return sum[V_W-1:gfsg_pkg::FRAC_W];
  endfunction

  // Coordinate lies in 0 .. size-1
  function automatic logic in_axis(input logic [R_W-1:0] r, input int unsigned size);
    return !r[R_W-1] && (r[R_W-2:0] < (R_W-1)'(size));
  endfunction

  logic adv;

  // Stage 1: displacements and load product
  logic                         b1_vld_q;
  gfsg_pkg::op_e                b1_op_q;
  logic                         b1_out_q;
  logic [gfsg_pkg::CELL_W-1:0]  b1_cell_q;
  logic [CRD_W-1:0]             b1_cx_q, b1_cy_q, b1_cz_q;
  logic signed [V_W-1:0]        b1_dx_q, b1_dy_q, b1_dz_q;
  logic signed [LOAD_W-1:0]     b1_prod_q, b1_prod_d;
  logic signed [DP_W-1:0]       dx_full, dy_full, dz_full;

  // Stage 2: upstream positions in Q38 and rounded load sample
  logic                         b2_vld_q;
  gfsg_pkg::op_e                b2_op_q;
  logic                         b2_out_q;
  logic [gfsg_pkg::CELL_W-1:0]  b2_cell_q;
  logic [V_W-1:0]               b2_vx_q, b2_vy_q, b2_vz_q;
  logic [V_W-1:0]               b2_vx_d, b2_vy_d, b2_vz_d;
  logic [gfsg_pkg::VALUE_W-1:0] b2_wdata_q, b2_wdata_d;
  logic [LOAD_W-1:0]            load_rnd;

  // Stage 3: rounded cells; store access issued here
  logic                         b3_vld_q;
  gfsg_pkg::op_e                b3_op_q;
  logic                         b3_out_q;
  logic [gfsg_pkg::CELL_W-1:0]  b3_cell_q;
  logic [R_W-1:0]               b3_rx_q, b3_ry_q, b3_rz_q;
  logic [gfsg_pkg::VALUE_W-1:0] b3_wdata_q;
  logic                         hit;
  logic [FULL_W-1:0]            flat;
  logic [gfsg_pkg::ADDR_W-1:0]  raddr;
  logic                         ram_we;

  // Stage 4: store data out of the RAM register
  logic                         b4_vld_q;
  logic                         b4_query_q;
  logic                         b4_hit_q;
  logic [gfsg_pkg::VALUE_W-1:0] rdata;

  // Output register
  logic                         out_vld_q, out_vld_d;
  logic [gfsg_pkg::VALUE_W-1:0] out_value_q, out_value_d;
  logic                         out_inb_q;

  // Everything moves unless a result waits and is not taken
  assign adv   = !out_vld_q || m_ready_i;
  assign pop_o = adv && !empty_i;

  // Stage 1 products
  always_comb begin
    dx_full   = $signed({1'b0, ratio_i.x}) * $signed(item_i.prod_x);
    dy_full   = $signed({1'b0, ratio_i.y}) * $signed(item_i.prod_y);
    dz_full   = $signed({1'b0, ratio_i.z}) * $signed(item_i.prod_z);
    b1_prod_d = $signed(item_i.sample) * $signed({1'b0, gfsg_pkg::NORM_Q32});
  end

  // Stage 2: subtract displacement from the cell position, round the load
  always_comb begin
    b2_vx_d    = V_W'({b1_cx_q, {gfsg_pkg::FRAC_W{1'b0}}}) - b1_dx_q;
    b2_vy_d    = V_W'({b1_cy_q, {gfsg_pkg::FRAC_W{1'b0}}}) - b1_dy_q;
    b2_vz_d    = V_W'({b1_cz_q, {gfsg_pkg::FRAC_W{1'b0}}}) - b1_dz_q;
    load_rnd   = b1_prod_q + LOAD_W'(64'h8000_0000) - LOAD_W'(b1_prod_q[LOAD_W-1]);
    b2_wdata_d = gfsg_pkg::VALUE_W'($signed(load_rnd[LOAD_W-1:32]));
  end

  // Stage 3: bounds check and store address
  always_comb begin
    hit = !b3_out_q
       && in_axis(b3_rx_q, X_SIZE)
       && in_axis(b3_ry_q, Y_SIZE)
       && in_axis(b3_rz_q, Z_SIZE);
    flat = FULL_W'(b3_rx_q[CRD_W-1:0]) * FULL_W'(PLANE)
         + FULL_W'(b3_ry_q[CRD_W-1:0]) * FULL_W'(Z_SIZE)
         + FULL_W'(b3_rz_q[CRD_W-1:0]);
    raddr  = gfsg_pkg::ADDR_W'(flat);
    ram_we = adv && b3_vld_q && (b3_op_q == gfsg_pkg::OP_LOAD);
  end

  gfsg_ram #(
    .WIDTH (gfsg_pkg::VALUE_W),
    .DEPTH (gfsg_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (b3_cell_q),
    .wdata_i (b3_wdata_q),
    .re_i    (adv),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Result word: zero when the upstream cell is outside
  always_comb begin
    out_vld_d   = out_vld_q;
    out_value_d = b4_hit_q ? rdata : '0;
    if (adv) begin
      out_vld_d = b4_vld_q && b4_query_q;
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_vld_q  <= 1'b0;
      b2_vld_q  <= 1'b0;
      b3_vld_q  <= 1'b0;
      b4_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      if (adv) begin
        b1_vld_q <= !empty_i;
        b2_vld_q <= b1_vld_q;
        b3_vld_q <= b2_vld_q;
        b4_vld_q <= b3_vld_q;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      b1_op_q    <= item_i.op;
      b1_out_q   <= item_i.outside;
      b1_cell_q  <= item_i.cell_idx;
      b1_cx_q    <= item_i.cx;
      b1_cy_q    <= item_i.cy;
      b1_cz_q    <= item_i.cz;
      b1_dx_q    <= dx_full[V_W-1:0];
      b1_dy_q    <= dy_full[V_W-1:0];
      b1_dz_q    <= dz_full[V_W-1:0];
      b1_prod_q  <= b1_prod_d;

      b2_op_q    <= b1_op_q;
      b2_out_q   <= b1_out_q;
      b2_cell_q  <= b1_cell_q;
      b2_vx_q    <= b2_vx_d;
      b2_vy_q    <= b2_vy_d;
      b2_vz_q    <= b2_vz_d;
      b2_wdata_q <= b2_wdata_d;

      b3_op_q    <= b2_op_q;
      b3_out_q   <= b2_out_q;
      b3_cell_q  <= b2_cell_q;
      b3_rx_q    <= round_cell(b2_vx_q);
      b3_ry_q    <= round_cell(b2_vy_q);
      b3_rz_q    <= round_cell(b2_vz_q);
      b3_wdata_q <= b2_wdata_q;

      b4_query_q <= (b3_op_q == gfsg_pkg::OP_QUERY);
      b4_hit_q   <= hit;

      out_value_q <= out_value_d;
      out_inb_q   <= b4_hit_q;
    end
  end

  assign m_valid_o     = out_vld_q;
  assign m_value_o     = out_value_q;
  assign m_in_bounds_o = out_inb_q;

endmodule

`default_nettype wire

// ----- src/grid_free_stream_gather.sv -----
// Top level of the free-streaming gather block: stream ports, step ratio
// registers, front part, item queue and back part.
// Depends on gfsg_pkg, gfsg_front, gfsg_queue, gfsg_back.
//
// Usage
//   Input stream (s_axis): tuser carries the opcode; a load (opcode 0)
//   scales the sample by 1/(4*pi) and writes it at the cell, a query
//   (opcode 1) returns the density at the upstream cell for the given
//   direction. Loads give no result, every query gives exactly one.
//   Output stream (m_axis): tdata is the density, tuser is the in-bounds
//   flag; an upstream cell outside the grid returns 0 with the flag low.
//   Config port: cfg_we_i writes cfg_data_i into the step ratio named by
//   cfg_index_i (0: x, 1: y, 2: z; 3 is ignored). Write only while idle.
// Timing
//   One word per cycle is accepted and one result per cycle delivered
//   while the output is taken. A query passes three front stages, the
//   queue, three back stages, the store read and the output register.
// Reset and stall
//   Reset empties all stages and sets every ratio to 1.0; the store is
//   not cleared and must be loaded before it is queried. A stalled output
//   holds the back part; the four-entry queue then fills and the front
//   part, and with it s_axis_tready_o, stops.
`default_nettype none

module grid_free_stream_gather #(
  parameter int unsigned X_SIZE      = 16,
  parameter int unsigned Y_SIZE      = 16,
  parameter int unsigned Z_SIZE      = 16,
  parameter int unsigned THETA_STEPS = 16,
  parameter int unsigned PHI_STEPS   = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [11:0] cell_index, [15:12] theta_index, [20:16] phi_index,
  // [52:21] sample_value, [55:53] zero
  input  wire logic [55:0] s_axis_tdata_i,
  // [0] opcode
  input  wire logic        s_axis_tuser_i,
  // Result stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [31:0] shifted_value
  output logic [31:0]      m_axis_tdata_o,
  // [0] in_bounds
  output logic             m_axis_tuser_o,
  // Configuration writes
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  gfsg_pkg::ratio_t ratio_q, ratio_d;
  gfsg_pkg::item_t  front_item, queue_item;
  logic             push, full, pop, empty;

  // Step ratio registers
  always_comb begin
    ratio_d = ratio_q;
    if (cfg_we_i) begin
      unique case (gfsg_pkg::cfg_idx_e'(cfg_index_i))
        gfsg_pkg::CFG_STEP_X: ratio_d.x = cfg_data_i;
        gfsg_pkg::CFG_STEP_Y: ratio_d.y = cfg_data_i;
        gfsg_pkg::CFG_STEP_Z: ratio_d.z = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q.x <= gfsg_pkg::RATIO_RESET;
      ratio_q.y <= gfsg_pkg::RATIO_RESET;
      ratio_q.z <= gfsg_pkg::RATIO_RESET;
    end else begin
      ratio_q <= ratio_d;
    end
  end

  gfsg_front #(
    .X_SIZE      (X_SIZE),
    .Y_SIZE      (Y_SIZE),
    .Z_SIZE      (Z_SIZE),
    .THETA_STEPS (THETA_STEPS),
    .PHI_STEPS   (PHI_STEPS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid_i),
    .s_ready_o  (s_axis_tready_o),
    .s_op_i     (gfsg_pkg::op_e'(s_axis_tuser_i)),
    .s_cell_i   (s_axis_tdata_i[11:0]),
    .s_theta_i  (s_axis_tdata_i[15:12]),
    .s_phi_i    (s_axis_tdata_i[20:16]),
    .s_sample_i (s_axis_tdata_i[52:21]),
    .push_o     (push),
    .item_o     (front_item),
    .full_i     (full)
  );

  gfsg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (queue_item),
    .empty_o (empty)
  );

  gfsg_back #(
    .X_SIZE (X_SIZE),
    .Y_SIZE (Y_SIZE),
    .Z_SIZE (Z_SIZE)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ratio_i       (ratio_q),
    .item_i        (queue_item),
    .empty_i       (empty),
    .pop_o         (pop),
    .m_valid_o     (m_axis_tvalid_o),
    .m_ready_i     (m_axis_tready_i),
    .m_value_o     (m_axis_tdata_o),
    .m_in_bounds_o (m_axis_tuser_o)
  );

endmodule

`default_nettype wire
